// ===== src/mtrl_pkg.sv =====
// Shared constants and control types for the multibit trie route lookup.
// No dependencies; every other file of the block imports this package.
package mtrl_pkg;

  // Trie geometry
  localparam int NUM_CHUNKS    = 1024;
  localparam int NEXT_HOP_BITS = 8;
  localparam int KEY_W         = 64;
  localparam int TOP_BITS      = 16;
  localparam int TOP_SIZE      = 1 << TOP_BITS;
  localparam int CHUNK_W       = 8;
  localparam int CHUNK_AW      = $clog2(NUM_CHUNKS);
  localparam int LEVEL_AW      = CHUNK_AW + CHUNK_W;
  localparam int LEVEL_SIZE    = NUM_CHUNKS << CHUNK_W;
  localparam int LEVELS        = 7;

  // Field widths
  localparam int KIND_W  = 2;
  localparam int LEVEL_W = 3;
  localparam int INDEX_W = 18;
  localparam int VALUE_W = 11;
  localparam int CHILD_W = VALUE_W;
  localparam int NH_W    = NEXT_HOP_BITS;
  localparam int OUT_NH_W = 8;
  localparam int DEPTH_W = 3;

  localparam logic [OUT_NH_W-1:0] DEFAULT_NH_RESET = 8'd10;

  // Item kinds
  localparam logic [KIND_W-1:0] KIND_LOOKUP   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_WR_NH    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_WR_CHILD = 2'd2;

  typedef struct packed {
    logic clear;   // zero all tables at the sweep address
    logic load;    // latch the incoming item
    logic start;   // set up a new walk
    logic step;    // walk one level
    logic write;   // perform the latched table write
    logic emit;    // load the result register
  } cmd_t;

  typedef struct packed {
    logic clear_last;
    logic walk_done;
  } status_t;

endpackage

// ===== src/mtrl_req_if.sv =====
// Request channel: lookups and table writes, valid/ready handshake.
// Depends on mtrl_pkg for field widths.
interface mtrl_req_if import mtrl_pkg::*; ;
  logic                valid;
  logic                ready;
  logic [KIND_W-1:0]   kind;
  logic [KEY_W-1:0]    key;
  logic [LEVEL_W-1:0]  level_number;
  logic [INDEX_W-1:0]  entry_index;
  logic [VALUE_W-1:0]  entry_value;

  modport source (output valid, kind, key, level_number, entry_index, entry_value,
                  input ready);
  modport sink   (input valid, kind, key, level_number, entry_index, entry_value,
                  output ready);
endinterface

// ===== src/mtrl_rsp_if.sv =====
// Result channel: one item per lookup, valid/ready handshake.
// Depends on mtrl_pkg for field widths.
interface mtrl_rsp_if import mtrl_pkg::*; ;
  logic                valid;
  logic                ready;
  logic [OUT_NH_W-1:0] next_hop;
  logic [DEPTH_W-1:0]  depth_reached;

  modport source (output valid, next_hop, depth_reached, input ready);
  modport sink   (input valid, next_hop, depth_reached, output ready);
endinterface

// ===== src/multibit_trie_route_lookup_unit.sv =====
// Top level of the multibit trie route lookup: controller plus datapath.
// Depends on mtrl_pkg, mtrl_req_if, mtrl_rsp_if, mtrl_ctrl, mtrl_datapath.
//
// Usage:
//   req  - request items. kind selects a lookup (key) or a write of one
//          next-hop or child entry (level_number, entry_index, entry_value).
//   rsp  - one result per lookup: next_hop and depth_reached. Writes and the
//          unused kind produce no result.
//   cfg_we / cfg_data - write the default next hop (reset value 10); write
//          only while the block is idle.
// Timing: one item at a time. A lookup makes one synchronous table read per
//   level, each read address built from the previous level's child entry.
//   A write is performed from the latched item in the write state.
// Reset: every table is cleared by a sweep of one address per cycle across
//   all levels in parallel, during which req.ready stays low.
// Stall: the result sits in an output register; the next request is taken
//   while it waits, and a finished lookup holds until the register is free.
module multibit_trie_route_lookup_unit import mtrl_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  mtrl_req_if.sink            req,
  mtrl_rsp_if.source          rsp,
  input  logic                cfg_we,
  input  logic [OUT_NH_W-1:0] cfg_data
);

  cmd_t    cmd;
  status_t status;

  mtrl_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .req_kind  (req.kind),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .status    (status),
    .cmd       (cmd)
  );

  mtrl_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .kind          (req.kind),
    .key           (req.key),
    .level_number  (req.level_number),
    .entry_index   (req.entry_index),
    .entry_value   (req.entry_value),
    .cfg_we        (cfg_we),
    .cfg_data      (cfg_data),
    .next_hop      (rsp.next_hop),
    .depth_reached (rsp.depth_reached)
  );

endmodule

// ===== src/mtrl_ctrl.sv =====
// Controller FSM: clearing sweep, item dispatch, walk sequencing, result register.
// Depends on mtrl_pkg (cmd_t, status_t, kind codes).
module mtrl_ctrl import mtrl_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  input  logic [KIND_W-1:0] req_kind,
  output logic              rsp_valid,
  input  logic              rsp_ready,
  input  status_t           status,
  output cmd_t              cmd
);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WALK,
    ST_FINISH,
    ST_WRITE
  } state_t;

  state_t state;
  logic   out_valid;
  logic   accept;
  logic   out_free;

  assign req_ready = (state == ST_IDLE);
  assign accept    = req_valid && req_ready;
  assign out_free  = !out_valid || rsp_ready;
  assign rsp_valid = out_valid;

  always_comb begin
    cmd       = '0;
    cmd.clear = (state == ST_CLEAR);
    cmd.load  = accept;
    cmd.start = accept && (req_kind == KIND_LOOKUP);
    cmd.step  = (state == ST_WALK);
    cmd.write = (state == ST_WRITE);
    cmd.emit  = (state == ST_FINISH) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      out_valid <= 1'b0;
    end else begin
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (rsp_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_CLEAR: begin
          if (status.clear_last) state <= ST_IDLE;
        end
        ST_IDLE: begin
          if (accept) begin
            if (req_kind == KIND_LOOKUP) begin
              state <= ST_WALK;
            end else if (req_kind == KIND_WR_NH || req_kind == KIND_WR_CHILD) begin
              state <= ST_WRITE;
            end
          end
        end
        ST_WALK: begin
          if (status.walk_done) state <= ST_FINISH;
        end
        ST_FINISH: begin
          if (out_free) state <= ST_IDLE;
        end
        ST_WRITE: begin
          state <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  a_emit_when_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (!out_valid || rsp_ready))
    else $error("result register overwritten while occupied");

  a_done_in_walk: assert property (@(posedge clk) disable iff (rst)
    status.walk_done |-> state == ST_WALK)
    else $error("walk completion outside of walk state");

  a_no_accept_clear: assert property (@(posedge clk) disable iff (rst)
    cmd.clear |-> !req_ready)
    else $error("item accepted during clearing sweep");

  a_finish_emits: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WALK && status.walk_done) |=> (state == ST_FINISH))
    else $error("walk completion not followed by finish");

endmodule

// ===== src/mtrl_datapath.sv =====
// Datapath: per-level table memories, walk registers, write decode, result payload.
// Depends on mtrl_pkg; driven by mtrl_ctrl through cmd_t / status_t.
module mtrl_datapath import mtrl_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  cmd_t                cmd,
  output status_t             status,
  input  logic [KIND_W-1:0]   kind,
  input  logic [KEY_W-1:0]    key,
  input  logic [LEVEL_W-1:0]  level_number,
  input  logic [INDEX_W-1:0]  entry_index,
  input  logic [VALUE_W-1:0]  entry_value,
  input  logic                cfg_we,
  input  logic [OUT_NH_W-1:0] cfg_data,
  output logic [OUT_NH_W-1:0] next_hop,
  output logic [DEPTH_W-1:0]  depth_reached
);

  // Latched item
  logic [KIND_W-1:0]  kind_q;
  logic [KEY_W-1:0]   key_q;
  logic [LEVEL_W-1:0] level_q;
  logic [INDEX_W-1:0] index_q;
  logic [VALUE_W-1:0] value_q;

  logic [OUT_NH_W-1:0] default_nh;
  logic [LEVEL_AW-1:0] clr_cnt;

  // Walk state
  logic [2:0]          step_cnt;
  logic [2:0]          prev;
  logic [OUT_NH_W-1:0] nh_run;
  logic [DEPTH_W-1:0]  depth_q;

  logic [NH_W-1:0]    rd_nh    [LEVELS];
  logic [CHILD_W-1:0] rd_child [LEVELS-1];
  logic [LEVELS-1:0]  rd_en;

  logic [NH_W-1:0]     cur_nh_raw;
  logic [OUT_NH_W-1:0] nh_eval;
  logic [CHILD_W-1:0]  cur_child;
  logic [CHILD_W-1:0]  child_m1;
  logic                child_ok;
  logic                eval;
  logic                walk_more;
  logic [5:0]          byte_lsb;
  logic [KEY_W-1:0]    key_shift;
  logic [LEVEL_AW-1:0] deep_raddr;

  // Write decode
  logic                wr_nh;
  logic                wr_child;
  logic                top_idx_ok;
  logic                deep_idx_ok;
  logic [NH_W-1:0]     nh_wdata;
  logic [CHILD_W-1:0]  child_wdata;
  logic [LEVEL_AW-1:0] deep_waddr;
  logic [TOP_BITS-1:0] top_waddr;
  logic                top_nh_we;
  logic                top_child_we;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_q  <= kind;
      key_q   <= key;
      level_q <= level_number;
      index_q <= entry_index;
      value_q <= entry_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      default_nh <= DEFAULT_NH_RESET;
    end else if (cfg_we) begin
      default_nh <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.clear) begin
      clr_cnt <= clr_cnt + LEVEL_AW'(1);
    end
  end

  assign status.clear_last = (clr_cnt == LEVEL_AW'(LEVEL_SIZE - 1));

  // Evaluate the level read in the previous cycle, then issue the next read
  assign prev       = step_cnt - 3'd1;
  assign eval       = cmd.step && (step_cnt != 3'd0);
  assign cur_nh_raw = rd_nh[prev];
  assign nh_eval    = (cur_nh_raw != '0) ? OUT_NH_W'(cur_nh_raw) : nh_run;

  always_comb begin
    if (prev == 3'(LEVELS - 1)) begin
      cur_child = '0;
    end else begin
      cur_child = rd_child[prev];
    end
  end

  assign child_ok  = (cur_child != '0) && (cur_child <= CHILD_W'(NUM_CHUNKS));
  assign walk_more = eval && child_ok;
  assign status.walk_done = eval && !child_ok;
  assign child_m1  = cur_child - CHILD_W'(1);

  // Level s uses the key byte just below the top bits, 8 bits further down per level
  assign byte_lsb   = 6'(KEY_W - TOP_BITS) - 6'(CHUNK_W * int'(step_cnt));
  assign key_shift  = key_q >> byte_lsb;
  assign deep_raddr = {child_m1[CHUNK_AW-1:0], key_shift[CHUNK_W-1:0]};

  always_ff @(posedge clk) begin
    if (rst) begin
      step_cnt <= '0;
    end else if (cmd.start) begin
      step_cnt <= '0;
    end else if (cmd.step) begin
      step_cnt <= step_cnt + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      nh_run  <= default_nh;
      depth_q <= '0;
    end else if (eval) begin
      nh_run <= nh_eval;
      if (walk_more) depth_q <= DEPTH_W'(step_cnt);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      next_hop      <= nh_run;
      depth_reached <= depth_q;
    end
  end

  // Writes: the clearing sweep shares the write port of every table
  assign wr_nh       = cmd.write && (kind_q == KIND_WR_NH);
  assign wr_child    = cmd.write && (kind_q == KIND_WR_CHILD) &&
                       (value_q <= VALUE_W'(NUM_CHUNKS));
  assign top_idx_ok  = ({1'b0, index_q} < (INDEX_W + 1)'(TOP_SIZE));
  assign deep_idx_ok = ({1'b0, index_q} < (INDEX_W + 1)'(LEVEL_SIZE));
  assign nh_wdata    = cmd.clear ? '0 : value_q[NH_W-1:0];
  assign child_wdata = cmd.clear ? '0 : value_q;
  assign deep_waddr  = cmd.clear ? clr_cnt : index_q[LEVEL_AW-1:0];
  assign top_waddr   = cmd.clear ? clr_cnt[TOP_BITS-1:0] : index_q[TOP_BITS-1:0];
  assign top_nh_we    = cmd.clear || (wr_nh && level_q == '0 && top_idx_ok);
  assign top_child_we = cmd.clear || (wr_child && level_q == '0 && top_idx_ok);

  // Level 0 tables
  logic [NH_W-1:0]    top_nh_mem    [TOP_SIZE];
  logic [CHILD_W-1:0] top_child_mem [TOP_SIZE];
  logic [NH_W-1:0]    top_nh_rdata;
  logic [CHILD_W-1:0] top_child_rdata;

  assign rd_en[0] = cmd.step && (step_cnt == 3'd0);

  always_ff @(posedge clk) begin
    if (top_nh_we) top_nh_mem[top_waddr] <= nh_wdata;
    if (rd_en[0]) top_nh_rdata <= top_nh_mem[key_q[KEY_W-1 -: TOP_BITS]];
  end

  always_ff @(posedge clk) begin
    if (top_child_we) top_child_mem[top_waddr] <= child_wdata;
    if (rd_en[0]) top_child_rdata <= top_child_mem[key_q[KEY_W-1 -: TOP_BITS]];
  end

  assign rd_nh[0]    = top_nh_rdata;
  assign rd_child[0] = top_child_rdata;

  // Deeper levels, one memory pair per level (next-hop memory only at the last level)
  for (genvar l = 1; l < LEVELS; l++) begin : g_level
    logic [NH_W-1:0] nh_mem [LEVEL_SIZE];
    logic [NH_W-1:0] nh_rdata;
    logic            nh_we;

    assign rd_en[l] = walk_more && (step_cnt == 3'(l));
    assign nh_we    = cmd.clear || (wr_nh && level_q == LEVEL_W'(l) && deep_idx_ok);

    always_ff @(posedge clk) begin
      if (nh_we) nh_mem[deep_waddr] <= nh_wdata;
      if (rd_en[l]) nh_rdata <= nh_mem[deep_raddr];
    end

    assign rd_nh[l] = nh_rdata;

    if (l < LEVELS - 1) begin : g_child
      logic [CHILD_W-1:0] child_mem [LEVEL_SIZE];
      logic [CHILD_W-1:0] child_rdata;
      logic               child_we;

      assign child_we = cmd.clear ||
                        (wr_child && level_q == LEVEL_W'(l) && deep_idx_ok);

      always_ff @(posedge clk) begin
        if (child_we) child_mem[deep_waddr] <= child_wdata;
        if (rd_en[l]) child_rdata <= child_mem[deep_raddr];
      end

      assign rd_child[l] = child_rdata;
    end
  end

  a_one_level_read: assert property (@(posedge clk) disable iff (rst)
    $onehot0(rd_en))
    else $error("more than one trie level read in a cycle");

  a_walk_bounded: assert property (@(posedge clk) disable iff (rst)
    walk_more |-> step_cnt < 3'(LEVELS))
    else $error("walk continued past the last level");

endmodule
